/* src/xtea_block_cipher_macros.svh */
// ----------------------------------------------------------------------------
// XTEA block cipher assertion macros
// Shared concurrent assertion forms; each use expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef XTEA_BLOCK_CIPHER_MACROS_SVH
`define XTEA_BLOCK_CIPHER_MACROS_SVH

// ante implies cons on the same clock edge
`define XTEA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// bad never holds at a clock edge
`define XTEA_ASSERT_NEVER(label, bad, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(bad)) \
    else $error(msg);

`endif

/* src/xtea_pkg.sv */
// ----------------------------------------------------------------------------
// XTEA package
// Beat types, pipeline record, command codes and round schedule helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package xtea_pkg;

  localparam int XTEA_ROUNDS    = 32;
  localparam int XTEA_WORD_W    = 32;
  localparam int XTEA_NUM_KEYS  = 4;
  localparam int XTEA_KEY_IDX_W = $clog2(XTEA_NUM_KEYS);

  localparam logic [XTEA_WORD_W-1:0] XTEA_DELTA     = 32'h9E37_79B9;
  localparam logic [XTEA_WORD_W-1:0] XTEA_NEG_DELTA = 32'h61C8_8647;

  localparam logic XTEA_CMD_ENCRYPT = 1'b0;
  localparam logic XTEA_CMD_DECRYPT = 1'b1;

  typedef struct packed {
    logic                   command;
    logic [XTEA_WORD_W-1:0] first_word;
    logic [XTEA_WORD_W-1:0] second_word;
    logic                   final_block;
  } xtea_in_t;

  typedef struct packed {
    logic [XTEA_WORD_W-1:0] first_result;
    logic [XTEA_WORD_W-1:0] second_result;
    logic                   final_out;
  } xtea_out_t;

  typedef struct packed {
    logic                   valid;
    logic                   cmd;
    logic [XTEA_WORD_W-1:0] w0;
    logic [XTEA_WORD_W-1:0] w1;
    logic                   fin;
  } xtea_pipe_t;

  typedef logic [XTEA_NUM_KEYS-1:0][XTEA_WORD_W-1:0] xtea_key_t;

  // Sum seen by half round number half when enciphering.
  function automatic logic [XTEA_WORD_W-1:0] xtea_enc_sum(int half);
    int steps;
    steps = (half >> 1) + (half & 1);
    return XTEA_DELTA * XTEA_WORD_W'(steps);
  endfunction

  // Sum seen by half round number half when deciphering: counts down from
  // rounds * delta.
  function automatic logic [XTEA_WORD_W-1:0] xtea_dec_sum(int rounds, int half);
    int steps;
    steps = (half >> 1) + (half & 1);
    return XTEA_DELTA * XTEA_WORD_W'(rounds) + XTEA_NEG_DELTA * XTEA_WORD_W'(steps);
  endfunction

  // The first word is updated on even halves of encipher, odd halves of decipher.
  function automatic logic xtea_upd_w0(logic cmd, logic odd);
    return (cmd == XTEA_CMD_ENCRYPT) ? !odd : odd;
  endfunction

endpackage

`default_nettype wire

/* src/xtea_block_cipher.sv */
// Pipeline: one input register, then two stages per half round, ahead of the
//   result strobe.
// Throughput: one block per cycle; busy is low whenever reset is released.
// Reset (synchronous, active low) clears all valid bits and the key words to
//   zero and holds busy high; results are strobed and cannot be stalled.
// ----------------------------------------------------------------------------
// XTEA block cipher
// Fully unrolled XTEA pipeline, encipher or decipher per beat, 128-bit key
// held in four writable words.
// ----------------------------------------------------------------------------
`default_nettype none
`include "xtea_block_cipher_macros.svh"

module xtea_block_cipher #(
  parameter int ROUNDS = xtea_pkg::XTEA_ROUNDS
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire xtea_pkg::xtea_in_t                     in_data,
  output logic                                        out_valid,
  output xtea_pkg::xtea_out_t                         out_data,
  input  wire logic                                   cfg_we,
  input  wire logic [xtea_pkg::XTEA_KEY_IDX_W-1:0]    cfg_index,
  input  wire logic [xtea_pkg::XTEA_WORD_W-1:0]       cfg_wdata
);

  localparam int HALVES  = 2 * ROUNDS;
  localparam int LATENCY = 2 * HALVES + 1;

  xtea_pkg::xtea_key_t  key_r;
  xtea_pkg::xtea_pipe_t in_pipe_r;
  xtea_pkg::xtea_pipe_t stage_pipe [HALVES+1];
  logic                 accept;

  assign busy   = !rst_n;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      key_r[cfg_index] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_pipe_r.valid <= 1'b0;
    end else begin
      in_pipe_r.valid <= accept;
      in_pipe_r.cmd   <= in_data.command;
      in_pipe_r.w0    <= in_data.first_word;
      in_pipe_r.w1    <= in_data.second_word;
      in_pipe_r.fin   <= in_data.final_block;
    end
  end

  assign stage_pipe[0] = in_pipe_r;

  for (genvar h = 0; h < HALVES; h++) begin : g_half
    xtea_half_round #(
      .ROUNDS (ROUNDS),
      .HALF   (h)
    ) u_half (
      .clk    (clk),
      .rst_n  (rst_n),
      .key    (key_r),
      .pipe_i (stage_pipe[h]),
      .pipe_o (stage_pipe[h+1])
    );
  end

  assign out_valid              = stage_pipe[HALVES].valid;
  assign out_data.first_result  = stage_pipe[HALVES].w0;
  assign out_data.second_result = stage_pipe[HALVES].w1;
  assign out_data.final_out     = stage_pipe[HALVES].fin;

  `XTEA_ASSERT_NEVER(no_phantom_beat, out_valid && !$past(accept, LATENCY), "result beat without a matching input beat")
  `XTEA_ASSERT_IMPL(final_mark_kept, out_valid, out_data.final_out == $past(in_data.final_block, LATENCY), "final-block mark lost in the pipeline")

endmodule

`default_nettype wire

/* src/xtea_half_round.sv */
// ----------------------------------------------------------------------------
// XTEA half round
// One Feistel half round in two register stages: mix and key/sum, then the
// add or subtract into the updated word.
// ----------------------------------------------------------------------------
`default_nettype none
`include "xtea_block_cipher_macros.svh"

module xtea_half_round #(
  parameter int ROUNDS = xtea_pkg::XTEA_ROUNDS,
  parameter int HALF   = 0
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire xtea_pkg::xtea_key_t  key,
  input  wire xtea_pkg::xtea_pipe_t pipe_i,
  output xtea_pkg::xtea_pipe_t      pipe_o
);

  localparam int W = xtea_pkg::XTEA_WORD_W;
  localparam logic ODD = 1'(HALF & 1);
  localparam logic [W-1:0] ENC_SUM = xtea_pkg::xtea_enc_sum(HALF);
  localparam logic [W-1:0] DEC_SUM = xtea_pkg::xtea_dec_sum(ROUNDS, HALF);
  // first-word updates pick the key by the low sum bits, second-word ones by bits 12:11
  localparam logic [xtea_pkg::XTEA_KEY_IDX_W-1:0] ENC_SEL =
    ODD ? ENC_SUM[12:11] : ENC_SUM[1:0];
  localparam logic [xtea_pkg::XTEA_KEY_IDX_W-1:0] DEC_SEL =
    ODD ? DEC_SUM[1:0] : DEC_SUM[12:11];

  logic                                 a_upd_w0;
  logic [W-1:0]                         a_src;
  logic [W-1:0]                         a_mix;
  logic [W-1:0]                         a_sum;
  logic [xtea_pkg::XTEA_KEY_IDX_W-1:0]  a_sel;
  logic [W-1:0]                         t_nxt;
  xtea_pkg::xtea_pipe_t                 a_r;
  logic [W-1:0]                         t_r;
  logic                                 b_upd_w0;
  logic [W-1:0]                         b_dst;
  logic [W-1:0]                         b_word;
  xtea_pkg::xtea_pipe_t                 b_nxt;
  xtea_pkg::xtea_pipe_t                 b_r;

  // Stage A: mix the other word, add sum and key in parallel
  always_comb begin
    a_upd_w0 = xtea_pkg::xtea_upd_w0(pipe_i.cmd, ODD);
    a_src    = a_upd_w0 ? pipe_i.w1 : pipe_i.w0;
    a_mix    = ((a_src << 4) ^ (a_src >> 5)) + a_src;
    a_sum    = (pipe_i.cmd == xtea_pkg::XTEA_CMD_DECRYPT) ? DEC_SUM : ENC_SUM;
    a_sel    = (pipe_i.cmd == xtea_pkg::XTEA_CMD_DECRYPT) ? DEC_SEL : ENC_SEL;
    t_nxt    = a_mix ^ (a_sum + key[a_sel]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.valid <= 1'b0;
    end else begin
      a_r <= pipe_i;
    end
  end

  always_ff @(posedge clk) begin
    t_r <= t_nxt;
  end

  // Stage B: fold the term into the updated word
  always_comb begin
    b_upd_w0 = xtea_pkg::xtea_upd_w0(a_r.cmd, ODD);
    b_dst    = b_upd_w0 ? a_r.w0 : a_r.w1;
    b_word   = (a_r.cmd == xtea_pkg::XTEA_CMD_DECRYPT) ? (b_dst - t_r) : (b_dst + t_r);
    b_nxt    = a_r;
    if (b_upd_w0) begin
      b_nxt.w0 = b_word;
    end else begin
      b_nxt.w1 = b_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r.valid <= 1'b0;
    end else begin
      b_r <= b_nxt;
    end
  end

  assign pipe_o = b_r;

  `XTEA_ASSERT_IMPL(keep_w1, pipe_o.valid && xtea_pkg::xtea_upd_w0(pipe_o.cmd, ODD), pipe_o.w1 == $past(pipe_i.w1, 2), "second word changed on a first-word half round")
  `XTEA_ASSERT_IMPL(keep_w0, pipe_o.valid && !xtea_pkg::xtea_upd_w0(pipe_o.cmd, ODD), pipe_o.w0 == $past(pipe_i.w0, 2), "first word changed on a second-word half round")

endmodule

`default_nettype wire
